// ===== src/cdf_pkg.sv =====
// Shared constants, codes and types of the command frame deframer.
// Used by the front end, command queue, back end, top level and checker.
package cdf_pkg;

	// Frame limits; lengths count the four header bytes.
	localparam int unsigned MAX_FRAME_BYTES = 128;
	localparam logic [15:0] MIN_FRAME_LEN = 16'd4;
	localparam logic [15:0] MAX_FRAME_LEN = 16'(MAX_FRAME_BYTES);
	localparam logic [15:0] SHELL_LEN     = 16'd10;
	localparam logic [15:0] FILTER_LEN    = 16'd6;

	localparam int unsigned HDR_TYPE_BYTES = 2;
	localparam int unsigned HDR_BYTES      = 4;
	localparam int unsigned CAPTURE_BYTES  = 6;

	localparam int unsigned MASK_W = 5;

	// Depth of the queue between front and back end.
	localparam int unsigned QDEPTH = 4;

	// Frame type codes (low bits of the type field, after the range check).
	localparam logic [2:0] TYPE_SHELL   = 3'd0;
	localparam logic [2:0] TYPE_RESTART = 3'd1;
	localparam logic [2:0] TYPE_REBOOT  = 3'd2;
	localparam logic [2:0] TYPE_UPGRADE = 3'd3;
	localparam logic [2:0] TYPE_FILTER  = 3'd4;
	localparam logic [15:0] TYPE_LAST   = 16'd4;

	// Result event codes.
	localparam logic [2:0] EV_BAD_LEN   = 3'd0;
	localparam logic [2:0] EV_UNKNOWN   = 3'd1;
	localparam logic [2:0] EV_WRONG_LEN = 3'd2;
	localparam logic [2:0] EV_SHELL     = 3'd3;
	localparam logic [2:0] EV_RESTART   = 3'd4;
	localparam logic [2:0] EV_REBOOT    = 3'd5;
	localparam logic [2:0] EV_UPGRADE   = 3'd6;
	localparam logic [2:0] EV_FILTER    = 3'd7;

	// One classified command as it travels from front to back end.
	typedef struct packed {
		logic [2:0]  event_code;
		logic [15:0] frame_type;
		logic [15:0] frame_length;
		logic [31:0] shell_ip;
		logic [15:0] shell_port;
		logic [1:0]  flt_mask;
		logic [1:0]  flt_val;
		logic        reset_sync;
	} cmd_t;

	typedef struct packed {
		logic push;
		cmd_t cmd;
	} q_wr_t;

	typedef struct packed {
		logic avail;
		cmd_t cmd;
	} q_rd_t;

endpackage

// ===== src/cdf_front.sv =====
// Front end of the deframer: takes stream items, assembles the header,
// captures payload bytes and classifies each finished frame. Uses cdf_pkg.
module cdf_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          opcode,
	input  logic [7:0]                    data_byte,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [cdf_pkg::MASK_W-1:0]    cfg_data,
	input  logic                          q_full,
	output cdf_pkg::q_wr_t                q_wr
);
	import cdf_pkg::*;

	logic [MASK_W-1:0] mask_q;
	logic [7:0]        bc_q, bc_d, bc_inc, pidx;
	logic [15:0]       type_q, type_d;
	logic [15:0]       len_q, len_d;
	logic [47:0]       cap_q, cap_d;
	logic              fin, bad, in_acc;
	logic [7:0]        mask8;
	cmd_t              cmd;

	assign cfg_ready = 1'b1;
	assign in_stall  = q_full;
	assign in_acc    = in_valid && !in_stall;
	assign bc_inc    = bc_q + 8'd1;
	assign pidx      = bc_q - 8'(HDR_BYTES);
	assign mask8     = {{(8 - MASK_W){1'b0}}, mask_q};

	// Next frame state and end-of-frame detection for the current item.
	always_comb begin
		bc_d   = bc_q;
		type_d = type_q;
		len_d  = len_q;
		cap_d  = cap_q;
		fin    = 1'b0;
		bad    = 1'b0;
		if (opcode) begin
			bc_d   = '0;
			type_d = '0;
			len_d  = '0;
			cap_d  = '0;
		end else if (bc_q < 8'(HDR_TYPE_BYTES)) begin
			type_d = {type_q[7:0], data_byte};
			bc_d   = bc_inc;
		end else if (bc_q < 8'(HDR_BYTES)) begin
			len_d = {len_q[7:0], data_byte};
			bc_d  = bc_inc;
			if (bc_inc == 8'(HDR_BYTES)) begin
				if (len_d < MIN_FRAME_LEN || len_d > MAX_FRAME_LEN) begin
					bad = 1'b1;
				end else if (len_d == MIN_FRAME_LEN) begin
					fin = 1'b1;
				end
			end
		end else begin
			if (pidx < 8'(CAPTURE_BYTES)) begin
				case (pidx[2:0])
					3'd0: cap_d[47:40] = data_byte;
					3'd1: cap_d[39:32] = data_byte;
					3'd2: cap_d[31:24] = data_byte;
					3'd3: cap_d[23:16] = data_byte;
					3'd4: cap_d[15:8]  = data_byte;
					3'd5: cap_d[7:0]   = data_byte;
					default: cap_d = cap_q;
				endcase
			end
			bc_d = bc_inc;
			if ({8'd0, bc_inc} >= len_q || bc_inc < 8'(HDR_BYTES)) begin
				fin = 1'b1;
			end
		end
	end

	// Classification of a finished frame.
	always_comb begin
		cmd              = '0;
		cmd.frame_type   = type_q;
		cmd.frame_length = len_d;
		if (bad) begin
			cmd.event_code = EV_BAD_LEN;
		end else if (type_q > TYPE_LAST || !mask8[type_q[2:0]]) begin
			cmd.event_code = EV_UNKNOWN;
		end else begin
			case (type_q[2:0])
				TYPE_SHELL: begin
					if (len_d != SHELL_LEN) begin
						cmd.event_code = EV_WRONG_LEN;
					end else begin
						cmd.event_code = EV_SHELL;
						cmd.shell_ip   = cap_d[47:16];
						cmd.shell_port = cap_d[15:0];
					end
				end
				TYPE_FILTER: begin
					if (len_d != FILTER_LEN) begin
						cmd.event_code = EV_WRONG_LEN;
					end else begin
						// Mask byte is payload byte 0, value byte is payload byte 1.
						cmd.event_code = EV_FILTER;
						cmd.flt_mask   = cap_d[41:40];
						cmd.flt_val    = cap_d[33:32];
						cmd.reset_sync = cap_d[47];
					end
				end
				TYPE_RESTART: cmd.event_code = EV_RESTART;
				TYPE_REBOOT:  cmd.event_code = EV_REBOOT;
				TYPE_UPGRADE: cmd.event_code = EV_UPGRADE;
				default:      cmd.event_code = EV_UNKNOWN;
			endcase
		end
	end

	assign q_wr.push = in_acc && (fin || bad);
	assign q_wr.cmd  = cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '1;
			bc_q   <= '0;
			type_q <= '0;
			len_q  <= '0;
			cap_q  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				mask_q <= cfg_data;
			end
			if (in_acc) begin
				if (fin || bad) begin
					bc_q   <= '0;
					type_q <= '0;
					len_q  <= '0;
					cap_q  <= '0;
				end else begin
					bc_q   <= bc_d;
					type_q <= type_d;
					len_q  <= len_d;
					cap_q  <= cap_d;
				end
			end
		end
	end

endmodule

// ===== src/cdf_queue.sv =====
// Short command queue between the front and back end of the deframer.
// Flip-flop storage of QDEPTH commands; uses cdf_pkg.
module cdf_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  cdf_pkg::q_wr_t wr,
	output logic           full,
	output cdf_pkg::q_rd_t rd,
	input  logic           pop
);
	import cdf_pkg::*;

	localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

	cmd_t             mem_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full     = (count_q == CNT_W'(QDEPTH));
	assign rd.avail = (count_q != '0);
	assign rd.cmd   = mem_q[rd_ptr_q];
	assign do_push  = wr.push && !full;
	assign do_pop   = pop && rd.avail;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr.cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/cdf_back.sv =====
// Back end of the deframer: carries out queued commands, keeps the filter
// flags and holds the result register toward the receiver. Uses cdf_pkg.
module cdf_back (
	input  logic           clk,
	input  logic           arst_n,
	input  cdf_pkg::q_rd_t rd,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [2:0]     event_code,
	output logic [15:0]    frame_type,
	output logic [15:0]    frame_length,
	output logic [31:0]    shell_ip,
	output logic [15:0]    shell_port,
	output logic           sync_only_flag,
	output logic           ext_squitter_only_flag,
	output logic           reset_sync
);
	import cdf_pkg::*;

	logic        out_valid_q;
	logic        sync_q, ext_q, sync_d, ext_d;
	logic [2:0]  event_q;
	logic [15:0] type_q, len_q, port_q;
	logic [31:0] ip_q;
	logic        rsync_q, osync_q, oext_q;

	assign pop = rd.avail && (!out_valid_q || !out_stall);

	// A filter command loads each flag whose mask bit is set.
	always_comb begin
		sync_d = sync_q;
		ext_d  = ext_q;
		if (rd.cmd.event_code == EV_FILTER) begin
			if (rd.cmd.flt_mask[0]) begin
				sync_d = rd.cmd.flt_val[0];
			end
			if (rd.cmd.flt_mask[1]) begin
				ext_d = rd.cmd.flt_val[1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sync_q      <= 1'b0;
			ext_q       <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
				sync_q      <= sync_d;
				ext_q       <= ext_d;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			event_q <= rd.cmd.event_code;
			type_q  <= rd.cmd.frame_type;
			len_q   <= rd.cmd.frame_length;
			ip_q    <= rd.cmd.shell_ip;
			port_q  <= rd.cmd.shell_port;
			rsync_q <= rd.cmd.reset_sync;
			osync_q <= sync_d;
			oext_q  <= ext_d;
		end
	end

	assign out_valid              = out_valid_q;
	assign event_code             = event_q;
	assign frame_type             = type_q;
	assign frame_length           = len_q;
	assign shell_ip               = ip_q;
	assign shell_port             = port_q;
	assign sync_only_flag         = osync_q;
	assign ext_squitter_only_flag = oext_q;
	assign reset_sync             = rsync_q;

endmodule

// ===== src/command_frame_deframer.sv =====
// Top level of the command frame deframer: front end, command queue, back end.
// Depends on cdf_pkg, cdf_front, cdf_queue and cdf_back.
//
// Usage:
//   Input channel (in_valid / in_stall): one item per cycle while in_stall is
//   low, either a stream byte (opcode 0, data_byte) or a new-connection event
//   (opcode 1) that drops any partial frame. Each frame is a big-endian 16-bit
//   type and 16-bit length (header included) followed by the payload.
//   Output channel (out_valid / out_stall): one result per finished frame or
//   per header with a length outside 4..128.
//   Config channel (cfg_valid / cfg_ready / cfg_data): the 5-bit handler
//   enable mask; cfg_ready is always high. Write it only while idle.
//   Throughput: one input item per cycle while in_stall is low. A finished
//   frame's result is written into the command queue, then into the result
//   register that drives the output. A four-entry command queue separates the
//   two sides; in_stall rises only when that queue is full, which happens after
//   the receiver holds out_stall long enough for four more results to pile up.
//   Reset: the mask returns to all ones, the filter flags and frame state
//   clear, and no result is pending.
module command_frame_deframer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          opcode,
	input  logic [7:0]                    data_byte,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [cdf_pkg::MASK_W-1:0]    cfg_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [2:0]                    event_code,
	output logic [15:0]                   frame_type,
	output logic [15:0]                   frame_length,
	output logic [31:0]                   shell_ip,
	output logic [15:0]                   shell_port,
	output logic                          sync_only_flag,
	output logic                          ext_squitter_only_flag,
	output logic                          reset_sync
);
	import cdf_pkg::*;

	q_wr_t q_wr;
	q_rd_t q_rd;
	logic  q_full;
	logic  q_pop;

	cdf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.data_byte (data_byte),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.q_wr      (q_wr)
	);

	cdf_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.full   (q_full),
		.rd     (q_rd),
		.pop    (q_pop)
	);

	cdf_back u_back (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.rd                     (q_rd),
		.pop                    (q_pop),
		.out_valid              (out_valid),
		.out_stall              (out_stall),
		.event_code             (event_code),
		.frame_type             (frame_type),
		.frame_length           (frame_length),
		.shell_ip               (shell_ip),
		.shell_port             (shell_port),
		.sync_only_flag         (sync_only_flag),
		.ext_squitter_only_flag (ext_squitter_only_flag),
		.reset_sync             (reset_sync)
	);

endmodule

// ===== src/cdf_checker.sv =====
// Port-level checks of the command frame deframer, bound to its top level.
// Depends on cdf_pkg and command_frame_deframer.
module cdf_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [2:0]                    event_code,
	input logic [15:0]                   frame_type,
	input logic [15:0]                   frame_length,
	input logic [31:0]                   shell_ip,
	input logic [15:0]                   shell_port,
	input logic                          reset_sync
);
	import cdf_pkg::*;

	// A stalled result stays in place with the same event, type, length and address.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(event_code) &&
			$stable(frame_type) && $stable(frame_length) && $stable(shell_ip))
		else $error("stalled result changed");

	// Address and port are only reported for a shell request.
	a_shell_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_code != EV_SHELL |-> shell_ip == '0 && shell_port == '0)
		else $error("shell fields set on a non-shell result");

	// A shell request always carries the shell frame length.
	a_shell_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_code == EV_SHELL |-> frame_length == SHELL_LEN &&
			frame_type == 16'(TYPE_SHELL))
		else $error("shell result with wrong type or length");

	// A bad-length result only reports a length outside the legal range.
	a_bad_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_code == EV_BAD_LEN |->
			frame_length < MIN_FRAME_LEN || frame_length > MAX_FRAME_LEN)
		else $error("bad-length result with a legal length");

	// Reset-sync is only raised by a filter update.
	a_rsync: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_code != EV_FILTER |-> !reset_sync)
		else $error("reset_sync set on a non-filter result");

endmodule

bind command_frame_deframer cdf_checker u_cdf_checker (.*);

// ===== test/tb_top.sv =====
// Self-checking testbench for command_frame_deframer: frames, config writes, stalls.
// Depends on cdf_pkg and the command_frame_deframer RTL; reads no files.
module tb_top;
	import cdf_pkg::*;

	typedef logic [7:0] byte_q_t[$];

	typedef struct packed {
		logic [2:0]  code;
		logic [15:0] ftype;
		logic [15:0] flen;
		logic [31:0] ip;
		logic [15:0] port;
		logic        sync_flag;
		logic        ext_flag;
		logic        rsync;
	} frame_result_t;

	localparam int DRAIN_CYCLES = 12;
	localparam int HOLD_CYCLES  = 150;
	localparam int PHASE_BYTES  = 410;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic opcode;
	logic [7:0] data_byte;
	logic cfg_valid;
	logic cfg_ready;
	logic [MASK_W-1:0] cfg_data;
	logic out_valid;
	logic out_stall;
	logic [2:0] event_code;
	logic [15:0] frame_type;
	logic [15:0] frame_length;
	logic [31:0] shell_ip;
	logic [15:0] shell_port;
	logic sync_only_flag;
	logic ext_squitter_only_flag;
	logic reset_sync;

	// Predicted deframer state.
	logic [MASK_W-1:0] handler_mask;
	logic [7:0]  rx_count;
	logic [15:0] hdr_type;
	logic [15:0] hdr_len;
	logic [47:0] payload;
	logic        sync_only;
	logic        ext_only;

	frame_result_t pending_results[$];
	int err_count;
	int bytes_sent;
	int send_idle_pct;
	int stall_pct;
	bit hold_req;
	bit hold_on;

	command_frame_deframer dut (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.in_valid               (in_valid),
		.in_stall               (in_stall),
		.opcode                 (opcode),
		.data_byte              (data_byte),
		.cfg_valid              (cfg_valid),
		.cfg_ready              (cfg_ready),
		.cfg_data               (cfg_data),
		.out_valid              (out_valid),
		.out_stall              (out_stall),
		.event_code             (event_code),
		.frame_type             (frame_type),
		.frame_length           (frame_length),
		.shell_ip               (shell_ip),
		.shell_port             (shell_port),
		.sync_only_flag         (sync_only_flag),
		.ext_squitter_only_flag (ext_squitter_only_flag),
		.reset_sync             (reset_sync)
	);

	always #1 clk = ~clk;

	task automatic report_err(input string msg);
		if (err_count < 40) begin
			$display("mismatch at %0t: %s", $realtime, msg);
		end
		err_count++;
	endtask

	function automatic void clear_frame_state();
		rx_count = '0;
		hdr_type = '0;
		hdr_len = '0;
		payload = '0;
	endfunction

	function automatic frame_result_t base_result(input logic [2:0] code);
		frame_result_t r;
		r = '0;
		r.code = code;
		r.ftype = hdr_type;
		r.flen = hdr_len;
		return r;
	endfunction

	// Classify a finished frame, apply any filter update and queue its result.
	function automatic void close_frame();
		frame_result_t r;
		logic [7:0] fmask;
		logic [7:0] fval;
		fmask = payload[47:40];
		fval = payload[39:32];
		if (hdr_type > TYPE_LAST || !handler_mask[hdr_type[2:0]]) begin
			r = base_result(EV_UNKNOWN);
		end else begin
			case (hdr_type[2:0])
				TYPE_SHELL: begin
					if (hdr_len != SHELL_LEN) begin
						r = base_result(EV_WRONG_LEN);
					end else begin
						r = base_result(EV_SHELL);
						r.ip = payload[47:16];
						r.port = payload[15:0];
					end
				end
				TYPE_FILTER: begin
					if (hdr_len != FILTER_LEN) begin
						r = base_result(EV_WRONG_LEN);
					end else begin
						if (fmask[0]) sync_only = fval[0];
						if (fmask[1]) ext_only = fval[1];
						r = base_result(EV_FILTER);
						r.rsync = fmask[7];
					end
				end
				TYPE_RESTART: r = base_result(EV_RESTART);
				TYPE_REBOOT:  r = base_result(EV_REBOOT);
				default:      r = base_result(EV_UPGRADE);
			endcase
		end
		r.sync_flag = sync_only;
		r.ext_flag = ext_only;
		pending_results.push_back(r);
		clear_frame_state();
	endfunction

	// Advance the predicted deframer by one accepted item.
	function automatic void deframe_item(input logic op, input logic [7:0] b);
		frame_result_t r;
		int idx;
		if (op) begin
			clear_frame_state();
		end else if (rx_count < 2) begin
			hdr_type = {hdr_type[7:0], b};
			rx_count++;
		end else if (rx_count < 4) begin
			hdr_len = {hdr_len[7:0], b};
			rx_count++;
			if (rx_count == 4) begin
				if (hdr_len < MIN_FRAME_LEN || hdr_len > MAX_FRAME_LEN) begin
					r = base_result(EV_BAD_LEN);
					r.sync_flag = sync_only;
					r.ext_flag = ext_only;
					pending_results.push_back(r);
					clear_frame_state();
				end else if (hdr_len == MIN_FRAME_LEN) begin
					close_frame();
				end
			end
		end else begin
			idx = int'(rx_count) - 4;
			if (idx < 6) payload[47 - 8 * idx -: 8] = b;
			rx_count++;
			if (rx_count >= hdr_len || rx_count < 4) close_frame();
		end
	endfunction

	// Entered and left at a falling edge.
	task automatic send_item(input logic op, input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		data_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		deframe_item(op, b);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_bytes(input byte_q_t bq);
		foreach (bq[i]) send_item(1'b0, bq[i]);
	endtask

	function automatic byte_q_t build_frame(input logic [15:0] t, input logic [15:0] len,
			input int plen);
		byte_q_t fr;
		fr = '{t[15:8], t[7:0], len[15:8], len[7:0]};
		repeat (plen) fr.push_back(8'($urandom));
		return fr;
	endfunction

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_mask(input logic [MASK_W-1:0] m);
		cfg_valid <= 1'b1;
		cfg_data <= m;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		handler_mask = m;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Mostly short frames; the longest legal length shows up now and then.
	function automatic logic [15:0] pick_len(input logic [15:0] t);
		int r;
		r = $urandom_range(99);
		if (t == 16'(TYPE_SHELL) && $urandom_range(99) < 70) return SHELL_LEN;
		if (t == 16'(TYPE_FILTER) && $urandom_range(99) < 70) return FILTER_LEN;
		if (r < 80) return 16'($urandom_range(4, 12));
		if (r < 97) return 16'($urandom_range(13, 127));
		return MAX_FRAME_LEN;
	endfunction

	task automatic send_random_frame();
		byte_q_t fr;
		logic [15:0] t;
		logic [15:0] len;
		int pick;
		int cut;
		pick = $urandom_range(99);
		t = ($urandom_range(99) < 85) ? 16'($urandom_range(0, 4)) : 16'($urandom);
		if (pick < 10) begin
			len = $urandom_range(1) ? 16'($urandom_range(0, 3))
				: 16'($urandom_range(129, 65535));
			send_bytes(build_frame(t, len, 0));
		end else if (pick < 17) begin
			send_item($urandom_range(99) < 70, 8'($urandom));
		end else begin
			len = pick_len(t);
			fr = build_frame(t, len, int'(len) - 4);
			if (pick < 25) begin
				// Connection drops part way through the frame.
				cut = $urandom_range(1, fr.size() - 1);
				fr = fr[0:cut - 1];
				send_bytes(fr);
				send_item(1'b1, 8'($urandom));
			end else begin
				send_bytes(fr);
			end
		end
	endtask

	task automatic test_directed_frames();
		send_idle_pct = 0;
		stall_pct = 0;
		send_bytes('{8'h00, 8'h01, 8'h00, 8'h04});
		send_bytes('{8'h00, 8'h02, 8'h00, 8'h05, 8'hAA});
		send_bytes('{8'h00, 8'h03, 8'h00, 8'h04});
		send_bytes('{8'h00, 8'h00, 8'h00, 8'h0A, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
		send_bytes('{8'h00, 8'h00, 8'h00, 8'h0A, 8'h0A, 8'h01, 8'h02, 8'h03, 8'h1F, 8'h90});
		send_bytes('{8'h00, 8'h00, 8'h00, 8'h04});
		send_bytes('{8'h00, 8'h04, 8'h00, 8'h06, 8'h83, 8'h03});
		send_bytes('{8'h00, 8'h04, 8'h00, 8'h06, 8'h02, 8'h00});
		send_bytes('{8'h00, 8'h04, 8'h00, 8'h07, 8'h01, 8'h00, 8'h00});
		send_bytes('{8'hFF, 8'hFF, 8'h00, 8'h04});
		send_bytes('{8'h00, 8'h05, 8'h00, 8'h04});
		send_bytes('{8'h00, 8'h01, 8'h00, 8'h03});
		send_bytes('{8'h00, 8'h01, 8'h00, 8'h81});
		send_bytes('{8'hFF, 8'hFF, 8'hFF, 8'hFF});
		// New connection inside a header and inside a payload.
		send_bytes('{8'h00, 8'h02, 8'h00});
		send_item(1'b1, 8'h00);
		send_bytes('{8'h00, 8'h02, 8'h00, 8'h08, 8'h11});
		send_item(1'b1, 8'hFF);
		send_bytes('{8'h00, 8'h01, 8'h00, 8'h04});
		wait_idle();
	endtask

	task automatic test_handler_mask();
		logic [MASK_W-1:0] masks[8];
		masks = '{5'h00, 5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'($urandom)};
		foreach (masks[i]) begin
			write_mask(masks[i]);
			send_bytes(build_frame(16'(TYPE_SHELL), SHELL_LEN, 6));
			send_bytes(build_frame(16'(TYPE_RESTART), MIN_FRAME_LEN, 0));
			send_bytes(build_frame(16'(TYPE_REBOOT), MIN_FRAME_LEN, 0));
			send_bytes(build_frame(16'(TYPE_UPGRADE), MIN_FRAME_LEN, 0));
			send_bytes(build_frame(16'(TYPE_FILTER), FILTER_LEN, 2));
			send_bytes(build_frame(16'd5, MIN_FRAME_LEN, 0));
			wait_idle();
		end
		write_mask(5'h1F);
	endtask

	task automatic test_random_traffic();
		int send_pct[3];
		int recv_pct[3];
		int stop_at;
		int next_cfg;
		send_pct = '{7, 79, 0};
		recv_pct = '{79, 7, 0};
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = send_pct[ph];
			stall_pct = recv_pct[ph];
			stop_at = bytes_sent + PHASE_BYTES;
			next_cfg = bytes_sent + 200;
			while (bytes_sent < stop_at) begin
				send_random_frame();
				if (bytes_sent >= next_cfg) begin
					next_cfg = bytes_sent + 200;
					if ($urandom_range(99) < 40) begin
						wait_idle();
						write_mask($urandom_range(1) ? 5'h1F : 5'($urandom));
					end
				end
			end
			wait_idle();
		end
		write_mask(5'h1F);
	endtask

	// The receiver holds off while short frames, mostly header-only, keep coming, so the
	// command queue fills and the input side has to stall.
	task automatic test_input_backpressure();
		send_idle_pct = 0;
		stall_pct = 0;
		hold_req = 1'b1;
		repeat (50) begin
			if ($urandom_range(3) == 0) begin
				send_bytes(build_frame(16'(TYPE_FILTER), FILTER_LEN, 2));
			end else begin
				send_bytes(build_frame(16'($urandom_range(1, 3)), MIN_FRAME_LEN, 0));
			end
		end
		wait_idle();
	endtask

	initial begin
		forever begin
			wait (hold_req);
			hold_on = 1'b1;
			repeat (HOLD_CYCLES) @(negedge clk);
			hold_on = 1'b0;
			hold_req = 1'b0;
		end
	end

	always @(negedge clk) begin
		out_stall <= hold_on || ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		frame_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_err($sformatf("unexpected result, event %0d", event_code));
			end else begin
				want = pending_results.pop_front();
				if (event_code !== want.code)
					report_err($sformatf("event %0d, want %0d", event_code, want.code));
				if (frame_type !== want.ftype)
					report_err($sformatf("type %h, want %h", frame_type, want.ftype));
				if (frame_length !== want.flen)
					report_err($sformatf("length %h, want %h", frame_length, want.flen));
				if (shell_ip !== want.ip)
					report_err($sformatf("ip %h, want %h", shell_ip, want.ip));
				if (shell_port !== want.port)
					report_err($sformatf("port %h, want %h", shell_port, want.port));
				if (sync_only_flag !== want.sync_flag)
					report_err($sformatf("sync flag %b, want %b", sync_only_flag,
						want.sync_flag));
				if (ext_squitter_only_flag !== want.ext_flag)
					report_err($sformatf("ext flag %b, want %b", ext_squitter_only_flag,
						want.ext_flag));
				if (reset_sync !== want.rsync)
					report_err($sformatf("reset sync %b, want %b", reset_sync, want.rsync));
			end
		end
	end

	initial begin
		#2000000;
		$display("tb_top: errors");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = 1'b0;
		data_byte = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		out_stall = 1'b0;
		hold_req = 1'b0;
		hold_on = 1'b0;
		err_count = 0;
		bytes_sent = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		handler_mask = 5'h1F;
		sync_only = 1'b0;
		ext_only = 1'b0;
		clear_frame_state();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed_frames();
		test_handler_mask();
		test_random_traffic();
		test_input_backpressure();

		wait_idle();
		if (err_count == 0 && pending_results.size() == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end
endmodule
